@@ design/utf8_to_cp866_transcoder_top_assert.svh @@
// assertion macros shared by the transcoder rtl files
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef UTF8_TO_CP866_TRANSCODER_TOP_ASSERT_SVH
`define UTF8_TO_CP866_TRANSCODER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold on every clock outside reset
`define U2C_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define U2C_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define U2C_ASSERT(name, clk, rst_n, prop, msg)

`define U2C_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

@@ design/u2c_pkg.sv @@
// types, constants and the cp866 mapping function for the transcoder
// no dependencies; used by every module of the block
package u2c_pkg;

  localparam int unsigned ResMax = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;

  localparam logic [7:0] QMark = 8'h3F;

  typedef enum logic [4:0] {
    PH_IDLE        = 5'b00001,
    PH_TWO_NEED1   = 5'b00010,
    PH_THREE_NEED2 = 5'b00100,
    PH_THREE_NEED1 = 5'b01000,
    PH_SKIP        = 5'b10000
  } phase_e;

  // one result: code point to map, or the terminator
  typedef struct packed {
    logic        term;
    logic [15:0] code;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [1:0]            cnt;
    res_t [ResMax-1:0]     res;
  } bundle_t;

  localparam res_t QMarkRes = '{term: 1'b0, code: {8'h00, QMark}};
  localparam res_t TermRes  = '{term: 1'b1, code: 16'h0000};

  function automatic logic pending(phase_e ph);
    return (ph == PH_TWO_NEED1) || (ph == PH_THREE_NEED2) || (ph == PH_THREE_NEED1);
  endfunction

  function automatic logic [7:0] map_code(logic [15:0] cp);
    logic [7:0] ch;
    ch = QMark;
    if (cp < 16'h0080) ch = cp[7:0];
    else if (cp >= 16'h0410 && cp <= 16'h043F) ch = 8'h80 + 8'(cp - 16'h0410);
    else if (cp >= 16'h0440 && cp <= 16'h044F) ch = 8'hE0 + 8'(cp - 16'h0440);
    else if (cp == 16'h0401) ch = 8'hF0;
    else if (cp == 16'h0451) ch = 8'hF1;
    else if (cp == 16'h00B0) ch = 8'hF8;
    else if (cp >= 16'h00C0 && cp <= 16'h00C5) ch = "A";
    else if (cp == 16'h00C7) ch = "C";
    else if (cp >= 16'h00C8 && cp <= 16'h00CB) ch = "E";
    else if (cp >= 16'h00CC && cp <= 16'h00CF) ch = "I";
    else if (cp == 16'h00D1) ch = "N";
    else if (cp >= 16'h00D2 && cp <= 16'h00D6) ch = "O";
    else if (cp == 16'h00D8) ch = "O";
    else if (cp >= 16'h00D9 && cp <= 16'h00DC) ch = "U";
    else if (cp == 16'h00DD) ch = "Y";
    else if (cp == 16'h00DF) ch = "s";
    else if (cp >= 16'h00E0 && cp <= 16'h00E5) ch = "a";
    else if (cp == 16'h00E7) ch = "c";
    else if (cp >= 16'h00E8 && cp <= 16'h00EB) ch = "e";
    else if (cp >= 16'h00EC && cp <= 16'h00EF) ch = "i";
    else if (cp == 16'h00F1) ch = "n";
    else if (cp >= 16'h00F2 && cp <= 16'h00F6) ch = "o";
    else if (cp == 16'h00F8) ch = "o";
    else if (cp >= 16'h00F9 && cp <= 16'h00FC) ch = "u";
    else if (cp == 16'h00FD) ch = "y";
    else if (cp == 16'h00FF) ch = "y";
    else if (cp >= 16'h0100 && cp <= 16'h0105) ch = "a";
    else if (cp >= 16'h0106 && cp <= 16'h010D) ch = "c";
    else if (cp >= 16'h010E && cp <= 16'h0111) ch = "d";
    else if (cp >= 16'h0112 && cp <= 16'h011B) ch = "e";
    else if (cp >= 16'h011C && cp <= 16'h0123) ch = "g";
    else if (cp >= 16'h0124 && cp <= 16'h0127) ch = "h";
    else if (cp >= 16'h0128 && cp <= 16'h0131) ch = "i";
    else if (cp >= 16'h0134 && cp <= 16'h0135) ch = "j";
    else if (cp >= 16'h0136 && cp <= 16'h0138) ch = "k";
    else if (cp >= 16'h0139 && cp <= 16'h0142) ch = "l";
    else if (cp >= 16'h0143 && cp <= 16'h0149) ch = "n";
    else if (cp >= 16'h014C && cp <= 16'h0151) ch = "o";
    else if (cp >= 16'h0154 && cp <= 16'h0159) ch = "r";
    else if (cp >= 16'h015A && cp <= 16'h0161) ch = "s";
    else if (cp >= 16'h0162 && cp <= 16'h0167) ch = "t";
    else if (cp >= 16'h0168 && cp <= 16'h0173) ch = "u";
    else if (cp >= 16'h0174 && cp <= 16'h0175) ch = "w";
    else if (cp >= 16'h0176 && cp <= 16'h0178) ch = "y";
    else if (cp >= 16'h0179 && cp <= 16'h017E) ch = "z";
    return ch;
  endfunction

endpackage

@@ design/utf8_to_cp866_transcoder_top.sv @@
// top level of the utf-8 to cp866 transcoder
// depends on u2c_pkg, u2c_front, u2c_queue, u2c_back
//
//  channel  direction  handshake                 payload
//  cfg      in         cfg_we_i                  cfg_wdata_i (max_chars)
//  in       in         in_valid_i / in_stall_o   text_byte_i, last_byte_i
//  out      out        out_valid_o / out_stall_i out_char_o, last_of_string_o
//
// the decoder takes one byte per cycle while the 4-bundle queue has room
// the output register shows the results of a bundle one at a time, so a
// byte with k results holds the back end until all k are shown; bytes with
// no result skip the queue; a first result is queued, then loaded into the output register
// reset clears decode state, queue and output valid flag; max_chars resets to 255
module utf8_to_cp866_transcoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_of_string_o
);
  import u2c_pkg::*;

  logic    push;
  logic    pop;
  logic    q_valid;
  logic    q_full;
  bundle_t push_bundle;
  bundle_t head_bundle;

  u2c_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .last_byte_i (last_byte_i),
    .full_i      (q_full),
    .push_o      (push),
    .bundle_o    (push_bundle)
  );

  u2c_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (push_bundle),
    .pop_i    (pop),
    .valid_o  (q_valid),
    .full_o   (q_full),
    .head_o   (head_bundle)
  );

  u2c_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_head_i         (head_bundle),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_char_o       (out_char_o),
    .last_of_string_o (last_of_string_o)
  );

endmodule

@@ design/u2c_front.sv @@
// front end: utf-8 decode state, character budget and result bundling
// depends on u2c_pkg
module u2c_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        text_byte_i,
  input  logic              last_byte_i,
  input  logic              full_i,
  output logic              push_o,
  output u2c_pkg::bundle_t  bundle_o
);
  import u2c_pkg::*;

  logic [7:0]  max_q;
  phase_e      ph_q, ph_d;
  logic [15:0] pc_q, pc_d;
  logic [7:0]  cw_q, cw_d;
  logic        te_q, te_d;

  logic        accept;
  logic        cont;
  logic [15:0] grown;
  logic        a_valid;
  logic [15:0] a_code;
  logic        restart;
  logic [1:0]  n;
  bundle_t     bnd;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign cont       = (text_byte_i[7:6] == 2'b10);
  assign grown      = {pc_q[9:0], text_byte_i[5:0]};

  always_comb begin
    ph_d    = ph_q;
    pc_d    = pc_q;
    cw_d    = cw_q;
    te_d    = te_q;
    n       = 2'd0;
    bnd     = '0;
    a_valid = 1'b0;
    a_code  = '0;
    restart = 1'b0;
    if (te_q) begin
      // swallow bytes after a zero byte until the string's last byte
      if (last_byte_i) begin
        ph_d = PH_IDLE;
        pc_d = '0;
        cw_d = '0;
        te_d = 1'b0;
      end
    end else if (text_byte_i == 8'h00) begin
      if (pending(ph_q) && (cw_q < max_q)) begin
        bnd.res[n] = QMarkRes;
        n = n + 2'd1;
      end
      bnd.res[n] = TermRes;
      n = n + 2'd1;
      ph_d = PH_IDLE;
      pc_d = '0;
      cw_d = '0;
      te_d = !last_byte_i;
    end else begin
      case (ph_q)
        PH_TWO_NEED1, PH_THREE_NEED1: begin
          a_valid = 1'b1;
          if (cont) begin
            a_code = grown;
            ph_d   = PH_IDLE;
            pc_d   = '0;
          end else begin
            a_code  = QMarkRes.code;
            restart = 1'b1;
          end
        end
        PH_THREE_NEED2: begin
          if (cont) begin
            pc_d = grown;
            ph_d = PH_THREE_NEED1;
          end else begin
            a_valid = 1'b1;
            a_code  = QMarkRes.code;
            restart = 1'b1;
          end
        end
        PH_SKIP: begin
          restart = !cont;
        end
        default: begin
          restart = 1'b1;
        end
      endcase
      if (a_valid && (cw_d < max_q)) begin
        bnd.res[n] = '{term: 1'b0, code: a_code};
        n = n + 2'd1;
        cw_d = cw_d + 8'd1;
      end
      // byte decoded afresh as a sequence start
      if (restart) begin
        ph_d = PH_IDLE;
        pc_d = '0;
        if (cw_d < max_q) begin
          if (!text_byte_i[7]) begin
            bnd.res[n] = '{term: 1'b0, code: {8'h00, text_byte_i}};
            n = n + 2'd1;
            cw_d = cw_d + 8'd1;
          end else if (text_byte_i[7:5] == 3'b110) begin
            ph_d = PH_TWO_NEED1;
            pc_d = {11'h000, text_byte_i[4:0]};
          end else if (text_byte_i[7:4] == 4'b1110) begin
            ph_d = PH_THREE_NEED2;
            pc_d = {12'h000, text_byte_i[3:0]};
          end else begin
            bnd.res[n] = QMarkRes;
            n = n + 2'd1;
            cw_d = cw_d + 8'd1;
            ph_d = PH_SKIP;
          end
        end
      end
      if (last_byte_i) begin
        if (pending(ph_d) && (cw_d < max_q)) begin
          bnd.res[n] = QMarkRes;
          n = n + 2'd1;
        end
        bnd.res[n] = TermRes;
        n = n + 2'd1;
        ph_d = PH_IDLE;
        pc_d = '0;
        cw_d = '0;
        te_d = 1'b0;
      end
    end
    bnd.cnt = n;
  end

  assign push_o   = accept && (n != 2'd0);
  assign bundle_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 8'hFF;
      ph_q  <= PH_IDLE;
      pc_q  <= '0;
      cw_q  <= '0;
      te_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (accept) begin
        ph_q <= ph_d;
        pc_q <= pc_d;
        cw_q <= cw_d;
        te_q <= te_d;
      end
    end
  end

endmodule

@@ design/u2c_queue.sv @@
// short bundle queue between the decoder front and the output back end
// depends on u2c_pkg and the assertion macro header
`include "utf8_to_cp866_transcoder_top_assert.svh"

module u2c_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u2c_pkg::bundle_t  bundle_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              full_o,
  output u2c_pkg::bundle_t  head_o
);
  import u2c_pkg::*;

  bundle_t                 mem_q [QDepth];
  logic [QPtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]          cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= bundle_i;
    end
  end

  `U2C_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o, "push into a full queue")
  `U2C_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && !valid_o, "pop from an empty queue")
  `U2C_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= (QPtrW+1)'(QDepth), "queue count overflow")

endmodule

@@ design/u2c_back.sv @@
// back end: walks the results of each bundle, maps to cp866, output register
// depends on u2c_pkg and the assertion macro header
`include "utf8_to_cp866_transcoder_top_assert.svh"

module u2c_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  u2c_pkg::bundle_t  q_head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_char_o,
  output logic              last_of_string_o
);
  import u2c_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q;
  logic       last_q;

  logic       load;
  logic       take;
  logic       last_in;
  res_t       cur;

  assign load    = !out_valid_q || !out_stall_i;
  assign take    = load && q_valid_i;
  assign cur     = q_head_i.res[idx_q];
  assign last_in = (idx_q == (q_head_i.cnt - 2'd1));
  assign pop_o   = take && last_in;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (take) begin
      idx_d       = last_in ? 2'd0 : idx_q + 2'd1;
      out_valid_d = 1'b1;
    end else if (load) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // the terminator carries code zero, which maps to zero
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_char_q <= map_code(cur.code);
      last_q     <= cur.term;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_char_o       = out_char_q;
  assign last_of_string_o = last_q;

  `U2C_ASSERT(a_idx_in_bundle, clk_i, rst_ni, !q_valid_i || (idx_q < q_head_i.cnt),
              "result index beyond bundle")
  `U2C_NEVER(a_pop_no_head, clk_i, rst_ni, pop_o && !q_valid_i, "pop without a queued bundle")
  `U2C_ASSERT(a_out_hold, clk_i, rst_ni,
              out_valid_q && out_stall_i |=> out_valid_q && $stable(out_char_q) && $stable(last_q),
              "stalled output beat changed")

endmodule
